### src/cmp_pkg.sv
// ----------------------------------------------------------------------------
// CoAP message parser package
// Phase codes, byte kinds, status codes and the parser state and result types.
// ----------------------------------------------------------------------------
package cmp_pkg;

   typedef enum logic [3:0] {
      PH_HEADER  = 4'd0,
      PH_TOKEN   = 4'd1,
      PH_OPTHDR  = 4'd2,
      PH_DEXT1   = 4'd3,
      PH_DEXT_HI = 4'd4,
      PH_DEXT_LO = 4'd5,
      PH_LEXT1   = 4'd6,
      PH_LEXT_HI = 4'd7,
      PH_LEXT_LO = 4'd8,
      PH_VALUE   = 4'd9,
      PH_PAYLOAD = 4'd10,
      PH_IGNORE  = 4'd11
   } phase_type;

   localparam logic [3:0] KIND_HEADER    = 4'd0;
   localparam logic [3:0] KIND_TOKEN     = 4'd1;
   localparam logic [3:0] KIND_OPTHDR    = 4'd2;
   localparam logic [3:0] KIND_DELTA_EXT = 4'd3;
   localparam logic [3:0] KIND_LEN_EXT   = 4'd4;
   localparam logic [3:0] KIND_VALUE     = 4'd5;
   localparam logic [3:0] KIND_MARKER    = 4'd6;
   localparam logic [3:0] KIND_PAYLOAD   = 4'd7;
   localparam logic [3:0] KIND_IGNORED   = 4'd8;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NIBBLE   = 2'd1;
   localparam logic [1:0] ST_TRUNC    = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic [7:0]  PAYLOAD_MARKER = 8'hff;
   localparam logic [3:0]  NIB_EXT1       = 4'd13;
   localparam logic [3:0]  NIB_EXT2       = 4'd14;
   localparam logic [3:0]  NIB_RESERVED   = 4'd15;
   localparam logic [16:0] EXT1_OFFSET    = 17'd13;
   localparam logic [16:0] EXT2_OFFSET    = 17'd269;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  header_count;
      logic [3:0]  token_left;
      logic [3:0]  length_nibble;
      logic [7:0]  ext_high_byte;
      logic [15:0] running_option;
      logic [16:0] value_left;
      logic [16:0] current_length;
      logic [1:0]  error_code;
      logic [1:0]  msg_type;
      logic [7:0]  msg_code;
      logic [15:0] message_id;
      logic [3:0]  token_length;
   } cmp_state_type;

   localparam cmp_state_type CMP_STATE_RESET = '{
      phase:          PH_HEADER,
      header_count:   2'd0,
      token_left:     4'd0,
      length_nibble:  4'd0,
      ext_high_byte:  8'd0,
      running_option: 16'd0,
      value_left:     17'd0,
      current_length: 17'd0,
      error_code:     ST_OK,
      msg_type:       2'd0,
      msg_code:       8'd0,
      message_id:     16'd0,
      token_length:   4'd0
   };

   typedef struct packed {
      logic [7:0]  byte_out;
      logic [3:0]  byte_kind;
      logic [15:0] option_number;
      logic [16:0] option_length;
      logic [1:0]  msg_type;
      logic [7:0]  msg_code;
      logic [15:0] message_id;
      logic [3:0]  token_length;
      logic [1:0]  status;
      logic        message_done;
   } cmp_result_type;

endpackage

### src/cmp_if.sv
// ----------------------------------------------------------------------------
// CoAP message parser channels
// Valid/ready channels for incoming message bytes and per-byte results.
// ----------------------------------------------------------------------------
interface cmp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface cmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_out;
   logic [3:0]  byte_kind;
   logic [15:0] option_number;
   logic [16:0] option_length;
   logic [1:0]  msg_type;
   logic [7:0]  msg_code;
   logic [15:0] message_id;
   logic [3:0]  token_length;
   logic [1:0]  status;
   logic        message_done;

   modport source (
      output valid, output byte_out, output byte_kind, output option_number,
      output option_length, output msg_type, output msg_code, output message_id,
      output token_length, output status, output message_done, input ready
   );
   modport sink (
      input valid, input byte_out, input byte_kind, input option_number,
      input option_length, input msg_type, input msg_code, input message_id,
      input token_length, input status, input message_done, output ready
   );
endinterface

### src/coap_message_parser.sv
// ----------------------------------------------------------------------------
// CoAP message parser
// Classifies each byte of a CoAP message and decodes header and option fields.
// ----------------------------------------------------------------------------
// One result per input byte, one byte per cycle while the result register
// drains. A byte is decoded in the cycle of its transfer from the registered
// parser state and lands in the result register, so results appear in the
// cycle after the byte and back to back. A new byte is taken whenever the
// result register is empty or is being drained in the same cycle. The parser
// state returns to the header phase after the byte flagged as end of message.
module coap_message_parser
   import cmp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   cmp_req_if.sink     req_chan,
   cmp_rsp_if.source   rsp_chan
);

   cmp_state_type  state_ff;
   cmp_state_type  state_in;
   cmp_result_type result_ff;
   cmp_result_type result_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           req_take;

   cmp_decode u_decode (
      .state_cur      (state_ff),
      .data_byte      (req_chan.data_byte),
      .end_of_message (req_chan.end_of_message),
      .state_next     (state_in),
      .result         (result_in)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_valid_in   = req_take || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CMP_STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.byte_out      = result_ff.byte_out;
   assign rsp_chan.byte_kind     = result_ff.byte_kind;
   assign rsp_chan.option_number = result_ff.option_number;
   assign rsp_chan.option_length = result_ff.option_length;
   assign rsp_chan.msg_type      = result_ff.msg_type;
   assign rsp_chan.msg_code      = result_ff.msg_code;
   assign rsp_chan.message_id    = result_ff.message_id;
   assign rsp_chan.token_length  = result_ff.token_length;
   assign rsp_chan.status        = result_ff.status;
   assign rsp_chan.message_done  = result_ff.message_done;

   // end of message puts the parser back at the first header byte
   a_eom_restart: assert property (@(posedge clock) disable iff (reset)
      req_take && req_chan.end_of_message |=>
         state_ff.phase == PH_HEADER && state_ff.header_count == 2'd0)
      else $error("parser not restarted after end of message");

   // an error held in the state always parks the parser in the ignore phase
   a_error_ignore: assert property (@(posedge clock) disable iff (reset)
      state_ff.error_code != ST_OK |-> state_ff.phase == PH_IGNORE)
      else $error("error latched outside ignore phase");

   // ignored bytes only follow an error
   a_ignored_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.byte_kind == KIND_IGNORED |-> result_ff.status != ST_OK)
      else $error("ignored byte without error status");

endmodule

### src/cmp_decode.sv
// ----------------------------------------------------------------------------
// CoAP byte decoder
// Next parser state and result for one message byte, given the current state.
// ----------------------------------------------------------------------------
module cmp_decode
   import cmp_pkg::*;
(
   input  cmp_state_type  state_cur,
   input  logic [7:0]     data_byte,
   input  logic           end_of_message,
   output cmp_state_type  state_next,
   output cmp_result_type result
);

   cmp_state_type nx;
   logic [3:0]    kind;
   logic          do_delta;
   logic          do_len;
   logic [16:0]   delta_val;
   logic [16:0]   len_val;
   logic [17:0]   opt_sum;

   always_comb begin
      nx        = state_cur;
      kind      = KIND_IGNORED;
      do_delta  = 1'b0;
      do_len    = 1'b0;
      delta_val = 17'd0;
      len_val   = 17'd0;

      case (state_cur.phase)
         PH_HEADER: begin
            kind = KIND_HEADER;
            case (state_cur.header_count)
               2'd0: begin
                  nx.msg_type     = data_byte[5:4];
                  nx.token_length = data_byte[3:0];
                  nx.msg_code     = 8'd0;
                  nx.message_id   = 16'd0;
                  nx.token_left   = data_byte[3:0];
               end
               2'd1: nx.msg_code = data_byte;
               2'd2: nx.message_id[15:8] = data_byte;
               default: begin
                  nx.message_id[7:0] = data_byte;
                  nx.phase = (state_cur.token_left != 4'd0) ? PH_TOKEN : PH_OPTHDR;
               end
            endcase
            nx.header_count = state_cur.header_count + 2'd1;
         end
         PH_TOKEN: begin
            kind = KIND_TOKEN;
            nx.token_left = state_cur.token_left - 4'd1;
            if (nx.token_left == 4'd0) begin
               nx.phase = PH_OPTHDR;
            end
         end
         PH_OPTHDR: begin
            if (data_byte == PAYLOAD_MARKER) begin
               kind     = KIND_MARKER;
               nx.phase = PH_PAYLOAD;
            end else begin
               kind              = KIND_OPTHDR;
               nx.length_nibble  = data_byte[3:0];
               nx.current_length = 17'd0;
               if (data_byte[7:4] == NIB_RESERVED || data_byte[3:0] == NIB_RESERVED) begin
                  nx.error_code = ST_NIBBLE;
                  nx.phase      = PH_IGNORE;
               end else if (data_byte[7:4] == NIB_EXT1) begin
                  nx.phase = PH_DEXT1;
               end else if (data_byte[7:4] == NIB_EXT2) begin
                  nx.phase = PH_DEXT_HI;
               end else begin
                  do_delta  = 1'b1;
                  delta_val = {13'd0, data_byte[7:4]};
               end
            end
         end
         PH_DEXT1: begin
            kind      = KIND_DELTA_EXT;
            do_delta  = 1'b1;
            delta_val = {9'd0, data_byte} + EXT1_OFFSET;
         end
         PH_DEXT_HI: begin
            kind             = KIND_DELTA_EXT;
            nx.ext_high_byte = data_byte;
            nx.phase         = PH_DEXT_LO;
         end
         PH_DEXT_LO: begin
            kind      = KIND_DELTA_EXT;
            do_delta  = 1'b1;
            delta_val = {1'b0, state_cur.ext_high_byte, data_byte} + EXT2_OFFSET;
         end
         PH_LEXT1: begin
            kind    = KIND_LEN_EXT;
            do_len  = 1'b1;
            len_val = {9'd0, data_byte} + EXT1_OFFSET;
         end
         PH_LEXT_HI: begin
            kind             = KIND_LEN_EXT;
            nx.ext_high_byte = data_byte;
            nx.phase         = PH_LEXT_LO;
         end
         PH_LEXT_LO: begin
            kind    = KIND_LEN_EXT;
            do_len  = 1'b1;
            len_val = {1'b0, state_cur.ext_high_byte, data_byte} + EXT2_OFFSET;
         end
         PH_VALUE: begin
            kind          = KIND_VALUE;
            nx.value_left = state_cur.value_left - 17'd1;
            if (nx.value_left == 17'd0) begin
               nx.phase = PH_OPTHDR;
            end
         end
         PH_PAYLOAD: kind = KIND_PAYLOAD;
         default: begin
            kind     = KIND_IGNORED;
            nx.phase = PH_IGNORE;
         end
      endcase

      opt_sum = {2'd0, state_cur.running_option} + {1'b0, delta_val};

      if (do_delta) begin
         if (opt_sum[17:16] != 2'd0) begin
            nx.error_code = ST_OVERFLOW;
            nx.phase      = PH_IGNORE;
         end else begin
            nx.running_option = opt_sum[15:0];
            if (nx.length_nibble == NIB_EXT1) begin
               nx.phase = PH_LEXT1;
            end else if (nx.length_nibble == NIB_EXT2) begin
               nx.phase = PH_LEXT_HI;
            end else begin
               do_len  = 1'b1;
               len_val = {13'd0, nx.length_nibble};
            end
         end
      end

      if (do_len) begin
         nx.current_length = len_val;
         nx.value_left     = len_val;
         nx.phase          = (len_val != 17'd0) ? PH_VALUE : PH_OPTHDR;
      end

      // last byte with the message still mid-field
      if (end_of_message && nx.error_code == ST_OK && nx.phase != PH_OPTHDR &&
          nx.phase != PH_PAYLOAD && nx.phase != PH_IGNORE) begin
         nx.error_code = ST_TRUNC;
      end

      result.byte_out      = data_byte;
      result.byte_kind     = kind;
      result.option_number = nx.running_option;
      result.option_length = nx.current_length;
      result.msg_type      = nx.msg_type;
      result.msg_code      = nx.msg_code;
      result.message_id    = nx.message_id;
      result.token_length  = nx.token_length;
      result.status        = nx.error_code;
      result.message_done  = end_of_message;

      state_next = end_of_message ? CMP_STATE_RESET : nx;
   end

endmodule

### bench/tb_coap_message_parser.sv
// ----------------------------------------------------------------------------
// CoAP message parser testbench
// Sends framed CoAP messages byte by byte, predicts each per-byte result from
// a parser of its own and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb_coap_message_parser
   import cmp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       eom;
   } wire_byte_type;

   // Directed messages, bit 8 marks the last byte of a message.
   localparam logic [8:0] DIRECTED_BYTES [0:42] = '{
      // clean: one token byte, delta ext1 option, marker and payload
      9'h061, 9'h045, 9'h012, 9'h034, 9'h05A, 9'h0D1, 9'h000, 9'h077,
      9'h0FF, 9'h000, 9'h1FF,
      // reserved delta nibble, trailing byte ignored
      9'h040, 9'h001, 9'h000, 9'h000, 9'h0F0, 9'h112,
      // delta ext2 at its maximum overflows the option number
      9'h070, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0E0, 9'h0FF, 9'h0FF, 9'h100,
      // length ext2 decoded, message ends before the value
      9'h050, 9'h003, 9'h000, 9'h001, 9'h01E, 9'h000, 9'h100,
      // marker as the final byte, empty payload
      9'h0C0, 9'h000, 9'h000, 9'h000, 9'h1FF,
      // header cut after its first byte
      9'h14F,
      // reserved length nibble on the last byte
      9'h080, 9'h0FF, 9'h0AA, 9'h055, 9'h10F
   };

   logic clock = 1'b0;
   logic reset;

   cmp_req_if req_chan();
   cmp_rsp_if rsp_chan();

   coap_message_parser u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   // Parser state of the predictor
   phase_type   cur_phase;
   logic [1:0]  hdr_count;
   logic [3:0]  token_left;
   logic [3:0]  len_nibble;
   logic [7:0]  ext_high;
   logic [15:0] opt_number;
   logic [16:0] value_left;
   logic [16:0] opt_length;
   logic [1:0]  parse_status;
   logic [1:0]  hdr_type;
   logic [7:0]  hdr_code;
   logic [15:0] hdr_id;
   logic [3:0]  hdr_tkl;

   wire_byte_type  bytes_to_send[$];
   cmp_result_type byte_reports_due[$];
   wire_byte_type  drive_byte;
   cmp_result_type want;
   cmp_result_type got;

   int  bytes_queued = 0;
   int  bytes_accepted = 0;
   int  results_checked = 0;
   int  messages_queued = 0;
   int  mismatches = 0;
   int  long_values_left = 2;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  req_sent = 1'b0;
   int  end_status_count[4] = '{0, 0, 0, 0};

   function automatic void clear_parser;
      cur_phase    = PH_HEADER;
      hdr_count    = 2'd0;
      token_left   = 4'd0;
      len_nibble   = 4'd0;
      ext_high     = 8'd0;
      opt_number   = 16'd0;
      value_left   = 17'd0;
      opt_length   = 17'd0;
      parse_status = ST_OK;
      hdr_type     = 2'd0;
      hdr_code     = 8'd0;
      hdr_id       = 16'd0;
      hdr_tkl      = 4'd0;
   endfunction

   function automatic void set_value_length(int unsigned len);
      opt_length = len[16:0];
      value_left = opt_length;
      cur_phase  = (value_left != 17'd0) ? PH_VALUE : PH_OPTHDR;
   endfunction

   function automatic void add_option_delta(int unsigned delta);
      int unsigned sum;
      sum = 32'(opt_number) + delta;
      if (sum > 32'hFFFF) begin
         parse_status = ST_OVERFLOW;
         cur_phase    = PH_IGNORE;
      end else begin
         opt_number = sum[15:0];
         if (len_nibble == NIB_EXT1)
            cur_phase = PH_LEXT1;
         else if (len_nibble == NIB_EXT2)
            cur_phase = PH_LEXT_HI;
         else
            set_value_length(32'(len_nibble));
      end
   endfunction

   function automatic cmp_result_type decode_coap_byte(logic [7:0] b, logic eom);
      cmp_result_type r;
      logic [3:0]     kind;
      logic [3:0]     delta_nib;
      kind      = KIND_IGNORED;
      delta_nib = b[7:4];
      case (cur_phase)
         PH_HEADER: begin
            kind = KIND_HEADER;
            case (hdr_count)
               2'd0: begin
                  hdr_type   = b[5:4];
                  hdr_tkl    = b[3:0];
                  hdr_code   = 8'd0;
                  hdr_id     = 16'd0;
                  token_left = b[3:0];
               end
               2'd1: hdr_code = b;
               2'd2: hdr_id[15:8] = b;
               default: begin
                  hdr_id[7:0] = b;
                  cur_phase = (token_left != 4'd0) ? PH_TOKEN : PH_OPTHDR;
               end
            endcase
            hdr_count = hdr_count + 2'd1;
         end
         PH_TOKEN: begin
            kind = KIND_TOKEN;
            token_left = token_left - 4'd1;
            if (token_left == 4'd0)
               cur_phase = PH_OPTHDR;
         end
         PH_OPTHDR: begin
            if (b == PAYLOAD_MARKER) begin
               kind = KIND_MARKER;
               cur_phase = PH_PAYLOAD;
            end else begin
               kind = KIND_OPTHDR;
               len_nibble = b[3:0];
               opt_length = 17'd0;
               if (delta_nib == NIB_RESERVED || len_nibble == NIB_RESERVED) begin
                  parse_status = ST_NIBBLE;
                  cur_phase = PH_IGNORE;
               end else if (delta_nib == NIB_EXT1) begin
                  cur_phase = PH_DEXT1;
               end else if (delta_nib == NIB_EXT2) begin
                  cur_phase = PH_DEXT_HI;
               end else begin
                  add_option_delta(32'(delta_nib));
               end
            end
         end
         PH_DEXT1: begin
            kind = KIND_DELTA_EXT;
            add_option_delta(32'(b) + 32'(EXT1_OFFSET));
         end
         PH_DEXT_HI: begin
            kind = KIND_DELTA_EXT;
            ext_high = b;
            cur_phase = PH_DEXT_LO;
         end
         PH_DEXT_LO: begin
            kind = KIND_DELTA_EXT;
            add_option_delta(32'({ext_high, b}) + 32'(EXT2_OFFSET));
         end
         PH_LEXT1: begin
            kind = KIND_LEN_EXT;
            set_value_length(32'(b) + 32'(EXT1_OFFSET));
         end
         PH_LEXT_HI: begin
            kind = KIND_LEN_EXT;
            ext_high = b;
            cur_phase = PH_LEXT_LO;
         end
         PH_LEXT_LO: begin
            kind = KIND_LEN_EXT;
            set_value_length(32'({ext_high, b}) + 32'(EXT2_OFFSET));
         end
         PH_VALUE: begin
            kind = KIND_VALUE;
            value_left = value_left - 17'd1;
            if (value_left == 17'd0)
               cur_phase = PH_OPTHDR;
         end
         PH_PAYLOAD: kind = KIND_PAYLOAD;
         default: begin
            kind = KIND_IGNORED;
            cur_phase = PH_IGNORE;
         end
      endcase

      // message ends mid-field with no earlier error
      if (eom && parse_status == ST_OK && cur_phase != PH_OPTHDR &&
          cur_phase != PH_PAYLOAD && cur_phase != PH_IGNORE)
         parse_status = ST_TRUNC;

      r = '{byte_out: b, byte_kind: kind, option_number: opt_number,
            option_length: opt_length, msg_type: hdr_type, msg_code: hdr_code,
            message_id: hdr_id, token_length: hdr_tkl, status: parse_status,
            message_done: eom};
      if (eom)
         clear_parser();
      return r;
   endfunction

   function automatic string describe_result(cmp_result_type r);
      return $sformatf({"byte %h kind %0d opt %0d len %0d type %0d code %h ",
                        "id %h tkl %0d st %0d done %b"},
                       r.byte_out, r.byte_kind, r.option_number, r.option_length,
                       r.msg_type, r.msg_code, r.message_id, r.token_length,
                       r.status, r.message_done);
   endfunction

   function automatic void queue_byte(logic [7:0] b, logic eom);
      bytes_to_send.push_back('{data: b, eom: eom});
      bytes_queued++;
   endfunction

   // Mostly well-formed messages with random content; some cut short, some noise.
   task automatic queue_random_message;
      logic [7:0] msg[$];
      logic [3:0] dn;
      logic [3:0] ln;
      logic [7:0] lx;
      int         tkl;
      int         nopt;
      int         roll;
      int         vlen;
      int         cut;
      tkl = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom_range(9, 15);
      msg.push_back({4'($urandom_range(0, 15)), 4'(tkl)});
      repeat (3 + tkl) msg.push_back(8'($urandom));
      nopt = $urandom_range(0, 4);
      for (int i = 0; i < nopt; i++) begin
         lx = 8'd0;
         roll = $urandom_range(0, 99);
         if (roll < 55)      dn = 4'($urandom_range(0, 12));
         else if (roll < 80) dn = NIB_EXT1;
         else if (roll < 96) dn = NIB_EXT2;
         else                dn = NIB_RESERVED;
         roll = $urandom_range(0, 99);
         if (roll < 82) begin
            ln = 4'($urandom_range(0, 12));
            vlen = ln;
         end else if (roll < 94) begin
            ln = NIB_EXT1;
            lx = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
            vlen = lx + 13;
         end else if (roll < 97 && long_values_left != 0) begin
            ln = NIB_EXT2;
            lx = 8'($urandom_range(0, 30));
            vlen = lx + 269;
            long_values_left--;
         end else begin
            ln = NIB_RESERVED;
            vlen = $urandom_range(0, 3);
         end
         msg.push_back({dn, ln});
         if (dn == NIB_EXT1) begin
            msg.push_back(8'($urandom));
         end else if (dn == NIB_EXT2) begin
            msg.push_back(($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 3))
                                                       : 8'($urandom));
            msg.push_back(8'($urandom));
         end
         if (ln == NIB_EXT1) begin
            msg.push_back(lx);
         end else if (ln == NIB_EXT2) begin
            msg.push_back(8'd0);
            msg.push_back(lx);
         end
         repeat (vlen) msg.push_back(8'($urandom));
      end
      if ($urandom_range(0, 99) < 60) begin
         msg.push_back(PAYLOAD_MARKER);
         repeat ($urandom_range(0, 10)) msg.push_back(8'($urandom));
      end

      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         msg.delete();
         repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom));
         cut = msg.size();
      end else if (roll < 20) begin
         cut = $urandom_range(1, msg.size());
      end else begin
         cut = msg.size();
      end
      for (int i = 0; i < cut; i++)
         queue_byte(msg[i], i == cut - 1);
      messages_queued++;
   endtask

   task automatic queue_random_bytes(int count);
      int target;
      target = bytes_queued + count;
      while (bytes_queued < target)
         queue_random_message();
   endtask

   // sender holds off until every byte is taken and every result is back
   task automatic wait_drained;
      do
         @(negedge clock);
      while (byte_reports_due.size() != 0 || bytes_accepted != bytes_queued);
   endtask

   // Byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_sent) begin
         if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            drive_byte = bytes_to_send.pop_front();
            req_chan.valid          <= 1'b1;
            req_chan.data_byte      <= drive_byte.data;
            req_chan.end_of_message <= drive_byte.eom;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result acceptor, with one long hold-off while bytes keep coming
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_checked >= 300) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= 150;
         hold_done <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor: check result transfers, then predict for accepted bytes
   always @(posedge clock) begin
      if (reset) begin
         req_sent = 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{byte_out: rsp_chan.byte_out, byte_kind: rsp_chan.byte_kind,
                    option_number: rsp_chan.option_number,
                    option_length: rsp_chan.option_length,
                    msg_type: rsp_chan.msg_type, msg_code: rsp_chan.msg_code,
                    message_id: rsp_chan.message_id,
                    token_length: rsp_chan.token_length, status: rsp_chan.status,
                    message_done: rsp_chan.message_done};
            results_checked++;
            if (byte_reports_due.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected result: %s", $realtime, describe_result(got));
               mismatches++;
            end else begin
               want = byte_reports_due.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("%0t: result %0d differs", $realtime, results_checked);
                     $display("   expected %s", describe_result(want));
                     $display("   actual   %s", describe_result(got));
                  end
                  mismatches++;
               end
            end
         end
         req_sent = req_chan.valid && req_chan.ready;
         if (req_sent) begin
            want = decode_coap_byte(req_chan.data_byte, req_chan.end_of_message);
            byte_reports_due.push_back(want);
            bytes_accepted++;
            if (want.message_done)
               end_status_count[want.status]++;
         end
      end
   end

   initial begin
      #3_200_000;
      $display("coap_message_parser: mismatch");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = 8'd0;
      req_chan.end_of_message = 1'b0;
      rsp_chan.ready = 1'b0;
      clear_parser();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 72;
      foreach (DIRECTED_BYTES[i]) begin
         queue_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
         if (DIRECTED_BYTES[i][8])
            messages_queued++;
      end
      wait_drained();

      queue_random_bytes(700);
      wait_drained();

      send_idle_pct = 72;
      recv_idle_pct = 29;
      queue_random_bytes(350);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_bytes(350);
      wait_drained();
      repeat (8) @(posedge clock);

      $display("Parsed %0d bytes in %0d messages under three idle mixes %s",
               bytes_accepted, messages_queued, "and a long result stall.");
      $display("Message ends: %0d clean, %0d reserved nibble, %0d truncated, %s",
               end_status_count[ST_OK], end_status_count[ST_NIBBLE],
               end_status_count[ST_TRUNC],
               $sformatf("%0d overflow; %0d mismatches.",
                         end_status_count[ST_OVERFLOW], mismatches));
      if (mismatches == 0 && byte_reports_due.size() == 0)
         $display("coap_message_parser: match");
      else
         $display("coap_message_parser: mismatch");
      $finish;
   end

endmodule

### filelist.f
src/cmp_pkg.sv
src/cmp_if.sv
src/cmp_decode.sv
src/coap_message_parser.sv
bench/tb_coap_message_parser.sv
